[rtl/core/lnm_pkg.sv]
package lnm_pkg;

  localparam int MapDepth = 16;
  localparam int IdxW = $clog2(MapDepth);
  localparam int CntW = $clog2(MapDepth + 1);
  localparam int RadW = 17;
  localparam int CountCfgW = 5;
  localparam int KindW = 3;
  localparam int PosW = 16;
  localparam int DiffW = PosW + 1;
  localparam int SqW = 2 * DiffW + 1;
  localparam int RootW = (SqW + 1) / 2;
  localparam int DistW = 17;
  localparam logic [DistW-1:0] StartDist = DistW'(100000);
  localparam int QDepth = 2;

  localparam logic [0:0] CfgRadius = 1'b0;
  localparam logic [0:0] CfgCount = 1'b1;

  localparam logic ReqLoad = 1'b0;
  localparam logic ReqQuery = 1'b1;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
  } query_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_FETCH, BK_DIFF, BK_SQUARE, BK_ROOT, BK_UPDATE, BK_DONE
  } bk_state_t;

endpackage

[rtl/core/lnm_front.sv]
module lnm_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic req_type,
  input  logic [lnm_pkg::IdxW-1:0] entry_index,
  input  lnm_pkg::query_t item,
  input  logic back_busy,
  output logic wr_en,
  output logic [lnm_pkg::IdxW-1:0] wr_addr,
  output lnm_pkg::query_t wr_data,
  output logic q_valid,
  input  logic q_ready,
  output lnm_pkg::query_t q_data
);

  lnm_pkg::query_t fifo [lnm_pkg::QDepth];
  logic [0:0] wptr, rptr;
  logic [1:0] count;
  logic push, pop, acc;

  // A load waits until no query is queued or walking, so it never changes the
  // table under an earlier query.
  assign in_ready = (req_type == lnm_pkg::ReqLoad) ? ((count == 2'd0) && !back_busy)
                  : (count != 2'(lnm_pkg::QDepth));
  assign acc = in_valid && in_ready;
  assign push = acc && (req_type == lnm_pkg::ReqQuery);
  assign pop = q_valid && q_ready;
  assign q_valid = (count != 2'd0);
  assign q_data = fifo[rptr];

  // Loads go straight to the table; queries wait in the queue.
  assign wr_en = acc && (req_type == lnm_pkg::ReqLoad);
  assign wr_addr = entry_index;
  assign wr_data = item;

  always_ff @(posedge clk) begin
    if (push) fifo[wptr] <= item;
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(lnm_pkg::QDepth)) else $error("queue overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (count == 2'(lnm_pkg::QDepth)) |-> !push) else $error("push into full queue");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 2'd1) else $error("count slip");
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (count == 2'd0) && !back_busy) else $error("load during a walk");

endmodule

[rtl/core/lnm_sqrt.sv]
module lnm_sqrt (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [lnm_pkg::SqW-1:0] radicand,
  output logic done,
  output logic [lnm_pkg::RootW-1:0] root
);

  localparam int StepW = $clog2(lnm_pkg::RootW + 1);
  logic [lnm_pkg::SqW+1:0] rem;
  logic [lnm_pkg::SqW+1:0] n;
  logic [StepW-1:0] steps;
  logic busy;
  logic [lnm_pkg::SqW+1:0] trial;
  logic [lnm_pkg::SqW+1:0] rem_sh;

  // Restoring digit recurrence: two radicand bits per cycle.
  always_comb begin
    rem_sh = {rem[lnm_pkg::SqW-1:0], n[lnm_pkg::SqW+1 -: 2]};
    trial = {(lnm_pkg::SqW + 2 - lnm_pkg::RootW - 2)'(0), root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        steps <= StepW'(lnm_pkg::RootW);
        rem <= '0;
        // The odd-width radicand is padded at the top so the bit pairs line up.
        n <= {1'b0, radicand, 1'b0};
        root <= '0;
      end else if (busy) begin
        n <= n << 2;
        if (rem_sh >= trial) begin
          rem <= rem_sh - trial;
          root <= {root[lnm_pkg::RootW-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          root <= {root[lnm_pkg::RootW-2:0], 1'b0};
        end
        steps <= steps - 1'b1;
        if (steps == StepW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without work");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy && !start |=> !done || !busy) else $error("sqrt state slip");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");

endmodule

[rtl/core/lnm_back.sv]
module lnm_back (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  logic [lnm_pkg::IdxW-1:0] wr_addr,
  input  lnm_pkg::query_t wr_data,
  input  logic q_valid,
  output logic q_ready,
  input  lnm_pkg::query_t q_data,
  input  logic [lnm_pkg::RadW-1:0] radius,
  input  logic [lnm_pkg::CntW-1:0] count_lim,
  output logic busy,
  output logic res_valid,
  input  logic res_ready,
  output logic res_matched,
  output logic [lnm_pkg::IdxW-1:0] res_id
);

  lnm_pkg::query_t mem [lnm_pkg::MapDepth];
  lnm_pkg::query_t ent, cur;
  lnm_pkg::bk_state_t state, state_next;
  logic [lnm_pkg::CntW-1:0] idx;
  logic signed [lnm_pkg::DiffW-1:0] dx, dy;
  logic [2*lnm_pkg::DiffW-1:0] sx, sy;
  logic [lnm_pkg::SqW-1:0] sq;
  logic sq_start, sq_done;
  logic [lnm_pkg::RootW-1:0] root;
  logic [lnm_pkg::DistW-1:0] best, second, d;
  logic [lnm_pkg::IdxW-1:0] best_idx;
  logic found;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    ent <= mem[idx[lnm_pkg::IdxW-1:0]];
  end

  lnm_sqrt u_sqrt (.clk, .rst, .start(sq_start), .radicand(sq), .done(sq_done), .root);

  assign busy = (state != lnm_pkg::BK_IDLE);

  // Root fits below 2^17; clamp is never needed but keeps widths honest.
  assign d = (root > lnm_pkg::RootW'(lnm_pkg::StartDist)) ? lnm_pkg::StartDist
           : root[lnm_pkg::DistW-1:0];

  always_comb begin
    state_next = state;
    q_ready = 1'b0;
    sq_start = 1'b0;
    unique case (state)
      lnm_pkg::BK_IDLE: begin
        q_ready = !res_valid;
        if (q_valid && !res_valid) state_next = lnm_pkg::BK_FETCH;
      end
      lnm_pkg::BK_FETCH:
        state_next = (idx >= count_lim) ? lnm_pkg::BK_DONE : lnm_pkg::BK_DIFF;
      lnm_pkg::BK_DIFF:
        state_next = (ent.kind == cur.kind) ? lnm_pkg::BK_SQUARE : lnm_pkg::BK_UPDATE;
      lnm_pkg::BK_SQUARE: begin
        sq_start = 1'b1;
        state_next = lnm_pkg::BK_ROOT;
      end
      lnm_pkg::BK_ROOT: if (sq_done) state_next = lnm_pkg::BK_UPDATE;
      lnm_pkg::BK_UPDATE: state_next = lnm_pkg::BK_FETCH;
      lnm_pkg::BK_DONE: state_next = lnm_pkg::BK_IDLE;
      default: state_next = lnm_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lnm_pkg::BK_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_valid && res_ready) res_valid <= 1'b0;
      if (state == lnm_pkg::BK_DONE) res_valid <= 1'b1;
    end
    unique case (state)
      lnm_pkg::BK_IDLE: begin
        cur <= q_data;
        idx <= '0;
        best <= lnm_pkg::StartDist;
        second <= lnm_pkg::StartDist;
        best_idx <= '0;
        found <= 1'b0;
      end
      lnm_pkg::BK_DIFF: begin
        dx <= lnm_pkg::DiffW'(cur.x) - lnm_pkg::DiffW'(ent.x);
        dy <= lnm_pkg::DiffW'(cur.y) - lnm_pkg::DiffW'(ent.y);
      end
      lnm_pkg::BK_SQUARE: ;
      lnm_pkg::BK_ROOT: ;
      lnm_pkg::BK_UPDATE: begin
        if (ent.kind == cur.kind) begin
          if (d < best) begin
            second <= best;
            best <= d;
            best_idx <= idx[lnm_pkg::IdxW-1:0];
            found <= 1'b1;
          end else if (d < second) begin
            second <= d;
          end
        end
        idx <= idx + 1'b1;
      end
      lnm_pkg::BK_DONE: begin
        res_matched <= found && (best < radius) && ((second - best) > radius);
        res_id <= (found && (best < radius) && ((second - best) > radius))
                  ? best_idx : '0;
      end
      default: ;
    endcase
  end

  // Squares of the registered differences, taken at full width.
  assign sx = dx * dx;
  assign sy = dy * dy;
  assign sq = {1'b0, sx} + {1'b0, sy};

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid) else $error("result dropped");
  a_idle_accept: assert property (@(posedge clk) disable iff (rst)
    q_ready |-> state == lnm_pkg::BK_IDLE) else $error("accept while busy");
  a_second_ge: assert property (@(posedge clk) disable iff (rst)
    state == lnm_pkg::BK_DONE |-> second >= best) else $error("order broken");

endmodule

[rtl/core/landmark_nearest_match.sv]
// Channel  | Dir | Contents
// s_axis   | in  | tdata: entry_index, mark_kind, pos_x_mm, pos_y_mm; tuser: req_type
// m_axis   | out | tdata: landmark_id; tuser: matched
// cfg      | in  | cfg_wr_en, cfg_index, cfg_data (0 radius, 1 map count)
// A load beat is written to the table in its accept cycle, but it is held off
// until no query is queued or being walked, so it never changes an earlier walk.
// A query walks map_count entries: an entry of its kind goes through fetch,
// difference, square, the two-bit-per-cycle square root and update, any other
// kind through fetch, difference and update, and a last fetch and a done state end it.
// Reset clears control only; the map table holds garbage until loaded.
// A two-entry query queue lets queries keep arriving while a query works,
// and the result register holds its beat until m_axis_tready.
module landmark_nearest_match (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // [3:0] entry_index, [6:4] mark_kind, [22:7] pos_x_mm, [38:23] pos_y_mm, zero pad
  input  logic [39:0] s_axis_tdata,
  // [0] req_type
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // [3:0] landmark_id, zero pad
  output logic [7:0] m_axis_tdata,
  // [0] matched
  output logic m_axis_tuser,
  input  logic cfg_wr_en,
  input  logic [0:0] cfg_index,
  input  logic [lnm_pkg::RadW-1:0] cfg_data
);

  logic [lnm_pkg::RadW-1:0] radius;
  logic [lnm_pkg::CountCfgW-1:0] map_count;
  logic [lnm_pkg::CntW-1:0] count_lim;
  lnm_pkg::query_t item, wr_data, q_data;
  logic wr_en, q_valid, q_ready, back_busy;
  logic [lnm_pkg::IdxW-1:0] wr_addr, res_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= lnm_pkg::RadW'(2333);
      map_count <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lnm_pkg::CfgRadius: radius <= cfg_data;
        lnm_pkg::CfgCount: map_count <= cfg_data[lnm_pkg::CountCfgW-1:0];
        default: ;
      endcase
    end
  end

  // Counts above the table depth walk the whole table.
  assign count_lim = (map_count > lnm_pkg::CountCfgW'(lnm_pkg::MapDepth))
                   ? lnm_pkg::CntW'(lnm_pkg::MapDepth) : map_count[lnm_pkg::CntW-1:0];

  assign item.kind = s_axis_tdata[6:4];
  assign item.x = s_axis_tdata[22:7];
  assign item.y = s_axis_tdata[38:23];

  lnm_front u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .req_type(s_axis_tuser), .entry_index(s_axis_tdata[3:0]), .item, .back_busy,
    .wr_en, .wr_addr, .wr_data, .q_valid, .q_ready, .q_data
  );

  lnm_back u_back (
    .clk, .rst, .wr_en, .wr_addr, .wr_data, .q_valid, .q_ready, .q_data,
    .radius, .count_lim, .busy(back_busy), .res_valid(m_axis_tvalid),
    .res_ready(m_axis_tready), .res_matched(m_axis_tuser), .res_id
  );

  assign m_axis_tdata = {4'b0, res_id};

endmodule

[tb/tb_landmark_nearest_match.sv]
// Scoreboard for the landmark matcher. It keeps its own copy of the map table and of
// the two registers, and it predicts each query's answer when the query beat is accepted.
class match_scoreboard;
  localparam longint unsigned FarMm = 100000;

  typedef struct {
    bit       matched;
    bit [3:0] id;
  } answer_t;

  int unsigned radius_mm;
  int unsigned count;
  bit [2:0]    tbl_kind[16];
  int          tbl_x[16];
  int          tbl_y[16];
  answer_t     answers[$];
  int          errors;
  int          results_seen;
  int          matches_seen;

  function new();
    radius_mm = 2333;
    count = 0;
    errors = 0;
    results_seen = 0;
    matches_seen = 0;
  endfunction

  // Floored square root, one result bit per pass from the top down.
  function longint unsigned floor_root(longint unsigned n);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function void set_reg(bit idx, int unsigned value);
    if (idx == lnm_pkg::CfgRadius) radius_mm = value & 32'h1FFFF;
    else count = value & 32'h1F;
  endfunction

  function void note_beat(bit req, bit [3:0] slot, bit [2:0] kind,
                          logic signed [15:0] px, logic signed [15:0] py);
    int unsigned n;
    longint unsigned best;
    longint unsigned second;
    longint unsigned d;
    longint dx;
    longint dy;
    bit found;
    answer_t a;
    if (req == lnm_pkg::ReqLoad) begin
      tbl_kind[slot] = kind;
      tbl_x[slot] = px;
      tbl_y[slot] = py;
      return;
    end
    n = (count > 16) ? 16 : count;
    best = FarMm;
    second = FarMm;
    found = 0;
    a.matched = 0;
    a.id = 0;
    for (int i = 0; i < n; i++) begin
      if (tbl_kind[i] == kind) begin
        dx = longint'(px) - tbl_x[i];
        dy = longint'(py) - tbl_y[i];
        d = floor_root(longint'(dx * dx + dy * dy));
        if (d < best) begin
          second = best;
          best = d;
          a.id = 4'(i);
          found = 1;
        end else if (d < second) begin
          second = d;
        end
      end
    end
    if (found && best < radius_mm && second - best > radius_mm) a.matched = 1;
    else a.id = 0;
    answers = {answers, a};
  endfunction

  task report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  task check_result(bit matched, bit [3:0] id);
    answer_t a;
    results_seen++;
    if (matched) matches_seen++;
    if (answers.size() == 0) begin
      report_mismatch($sformatf("result beat matched=%0d id=%0d with nothing expected",
                                matched, id));
      return;
    end
    a = answers.pop_front();
    if (a.matched != matched)
      report_mismatch($sformatf("matched got %0d want %0d", matched, a.matched));
    if (a.id != id)
      report_mismatch($sformatf("landmark_id got %0d want %0d", id, a.id));
  endtask

  function int pending();
    return answers.size();
  endfunction
endclass

module tb_landmark_nearest_match;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_wr_en;
  logic [0:0]  cfg_index;
  logic [lnm_pkg::RadW-1:0] cfg_data;

  match_scoreboard sb;

  // Receiver controls. The main sequence raises hold_req to make the receiver stop
  // taking results for a long stretch, and quiet_rx to remove receiver stalls.
  bit hold_req;
  bit quiet_rx;
  bit quiet_tx;
  int held_cycles;

  landmark_nearest_match u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Mostly short gaps, now and then a long one.
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // Sends one beat, returns after acceptance and any gap. Inputs move on the falling
  // edge; the handshake is judged at the rising edge, before the block updates.
  task send_beat(bit req, bit [3:0] slot, bit [2:0] kind,
                 logic signed [15:0] px, logic signed [15:0] py);
    int gap;
    @(negedge clk);
    s_axis_tdata = {1'b0, py, px, kind, slot};
    s_axis_tuser = req;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_beat(req, slot, kind, px, py);
    gap = quiet_tx ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
      s_axis_tdata = 40'({$urandom, $urandom});
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task write_reg(bit idx, int unsigned value);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = lnm_pkg::RadW'(value);
    @(posedge clk);
    sb.set_reg(idx, value);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Stops offering beats and waits until every expected answer has come back, then
  // lets the block sit quiet before anything else changes.
  task wait_idle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task set_phase(int unsigned radius, int unsigned count);
    wait_idle();
    write_reg(lnm_pkg::CfgRadius, radius);
    write_reg(lnm_pkg::CfgCount, count);
  endtask

  // A random beat: mostly loads spread over the field and queries placed close to a
  // loaded entry, with some queries anywhere in the full coordinate range.
  task random_beat();
    int r;
    int i;
    int off_x;
    int off_y;
    int spread;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      if ($urandom_range(0, 3) == 0)
        send_beat(lnm_pkg::ReqLoad, 4'($urandom), 3'($urandom), 16'($urandom),
                  16'($urandom));
      else
        send_beat(lnm_pkg::ReqLoad, 4'($urandom), 3'($urandom_range(0, 3)),
                  16'(int'($urandom_range(0, 60000)) - 30000),
                  16'(int'($urandom_range(0, 60000)) - 30000));
    end else if (r < 85) begin
      i = $urandom_range(0, 15);
      spread = (sb.radius_mm > 6000) ? 6000 : sb.radius_mm + 50;
      off_x = int'($urandom_range(0, 2 * spread)) - spread;
      off_y = int'($urandom_range(0, 2 * spread)) - spread;
      send_beat(lnm_pkg::ReqQuery, 4'($urandom), sb.tbl_kind[i],
                16'(sb.tbl_x[i] + off_x), 16'(sb.tbl_y[i] + off_y));
    end else begin
      send_beat(lnm_pkg::ReqQuery, 4'($urandom), 3'($urandom), 16'($urandom),
                16'($urandom));
    end
  endtask

  // Results are checked at the rising edge where the beat is taken.
  always @(posedge clk) begin
    if (!rst && sb != null && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata[3:0]);
  end

  // Receiver: random stalls, or a long hold-off counted here when asked for.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_axis_tready = 1'b0;
        held_cycles = 0;
        while (held_cycles < 3000) begin
          @(negedge clk);
          held_cycles++;
        end
        hold_req = 1'b0;
      end else if (stall > 0) begin
        m_axis_tready = 1'b0;
        stall--;
      end else begin
        m_axis_tready = 1'b1;
        if (!quiet_rx && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  initial begin
    #5ms;
    $display("timeout with %0d answers outstanding", sb.pending());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned radii[6];
    int unsigned counts[6];
    sb = new();
    hold_req = 0;
    quiet_rx = 0;
    quiet_tx = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty walk straight after reset: the count is zero, so no entry is read.
    send_beat(lnm_pkg::ReqQuery, 4'd0, 3'd0, 16'sd0, 16'sd0);
    send_beat(lnm_pkg::ReqQuery, 4'hF, 3'd7, -16'sd32768, 16'sd32767);

    // Fill every slot before the phase queries below, with two opposite corners of
    // the field among the positions.
    send_beat(lnm_pkg::ReqLoad, 4'd0, 3'd1, -16'sd32768, -16'sd32768);
    send_beat(lnm_pkg::ReqLoad, 4'd1, 3'd1, 16'sd32767, 16'sd32767);
    send_beat(lnm_pkg::ReqLoad, 4'd2, 3'd7, 16'sd0, 16'sd0);
    send_beat(lnm_pkg::ReqLoad, 4'd3, 3'd2, 16'sd1000, 16'sd0);
    send_beat(lnm_pkg::ReqLoad, 4'd4, 3'd2, 16'sd2000, 16'sd0);
    for (int i = 5; i < 16; i++)
      send_beat(lnm_pkg::ReqLoad, 4'(i), 3'd0, 16'(i * 3000 - 30000),
                16'(30000 - i * 2500));

    set_phase(2333, 16);
    send_beat(lnm_pkg::ReqQuery, 4'd0, 3'd7, 16'sd0, 16'sd0);            // exact hit
    send_beat(lnm_pkg::ReqQuery, 4'd0, 3'd7, 16'sd2332, 16'sd0);         // just inside
    send_beat(lnm_pkg::ReqQuery, 4'd0, 3'd7, 16'sd2333, 16'sd0);         // on the radius
    send_beat(lnm_pkg::ReqQuery, 4'd0, 3'd1, -16'sd32768, -16'sd32768);  // far corner
    send_beat(lnm_pkg::ReqQuery, 4'd0, 3'd1, 16'sd32767, -16'sd32768);   // between corners
    send_beat(lnm_pkg::ReqQuery, 4'd0, 3'd2, 16'sd1400, 16'sd0);         // not unique
    send_beat(lnm_pkg::ReqQuery, 4'd0, 3'd5, 16'sd0, 16'sd0);            // kind absent

    set_phase(0, 31);   // count above the table depth, zero radius
    send_beat(lnm_pkg::ReqQuery, 4'd0, 3'd7, 16'sd0, 16'sd0);
    send_beat(lnm_pkg::ReqQuery, 4'd0, 3'd1, 16'sd32767, 16'sd32767);

    set_phase(131071, 1);
    send_beat(lnm_pkg::ReqQuery, 4'd0, 3'd1, 16'sd0, 16'sd0);

    // Random phases across register settings, the extremes among them.
    radii = '{2333, 0, 131071, 500, 4000, 2333};
    counts = '{16, 0, 1, 17, 8, 16};
    for (int p = 0; p < 6; p++) begin
      set_phase(radii[p], counts[p]);
      quiet_rx = (p == 3);
      quiet_tx = (p == 3);
      for (int k = 0; k < 95; k++) random_beat();
    end
    quiet_rx = 0;
    quiet_tx = 0;

    // The receiver stops for a long stretch while queries keep coming, so the
    // queue fills and the input stalls.
    set_phase(3000, 16);
    hold_req = 1'b1;
    for (int k = 0; k < 20; k++) random_beat();

    wait_idle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    $display("Covered loads, queries under radii from 0 to 131071 and counts from 0 to 31,");
    $display("with %0d answers checked, %0d of them matches.", sb.results_seen,
             sb.matches_seen);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

[files.f]
rtl/core/lnm_pkg.sv
rtl/core/lnm_front.sv
rtl/core/lnm_sqrt.sv
rtl/core/lnm_back.sv
rtl/core/landmark_nearest_match.sv
tb/tb_landmark_nearest_match.sv
